>>> design/sssd_pkg.sv
// ----------------------------------------------------------------------------
// sssd_pkg
// Shared types, codes and the glyph table of the seven-segment scan dimmer.
// ----------------------------------------------------------------------------
package sssd_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int PERIOD_W    = 16;
  localparam int DIM_W       = 14;
  localparam int POS_W       = 4;
  localparam int GLYPH_W     = 4;
  localparam int SEG_W       = 8;
  localparam int SLOT_W      = 3;
  localparam int ROT_W       = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SLOT_PERIOD  = 2'd0,
    REG_BLANK_PERIOD = 2'd1,
    REG_DIM_LEVEL    = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  localparam logic [PERIOD_W-1:0] SLOT_PERIOD_RST  = 16'd1000;
  localparam logic [PERIOD_W-1:0] BLANK_PERIOD_RST = 16'd1000;
  localparam logic [DIM_W-1:0]    DIM_LEVEL_RST    = 14'd0;

  // Five slots per scan cycle; positions below the rotated group are dimmed
  localparam logic [SLOT_W-1:0] SLOT_FIRST    = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_ROTATED  = 3'd5;
  localparam logic [POS_W-1:0]  POS_FIRST     = 4'd1;
  localparam logic [POS_W-1:0]  POS_ROT_BASE  = 4'd5;
  localparam logic [POS_W-1:0]  POS_NONE      = 4'd0;

  localparam logic [SEG_W-1:0] SEG_A  = 8'h01;
  localparam logic [SEG_W-1:0] SEG_B  = 8'h02;
  localparam logic [SEG_W-1:0] SEG_C  = 8'h04;
  localparam logic [SEG_W-1:0] SEG_D  = 8'h08;
  localparam logic [SEG_W-1:0] SEG_E  = 8'h10;
  localparam logic [SEG_W-1:0] SEG_F  = 8'h20;
  localparam logic [SEG_W-1:0] SEG_G  = 8'h40;
  localparam logic [SEG_W-1:0] SEG_DP = 8'h80;
  localparam logic [SEG_W-1:0] SEG_OFF = 8'h00;

  typedef enum logic [GLYPH_W-1:0] {
    GL_0 = 4'd0, GL_1 = 4'd1, GL_2 = 4'd2, GL_3 = 4'd3, GL_4 = 4'd4,
    GL_5 = 4'd5, GL_6 = 4'd6, GL_7 = 4'd7, GL_8 = 4'd8, GL_9 = 4'd9,
    GL_BLANK = 4'd10, GL_MINUS = 4'd11, GL_P = 4'd12, GL_U = 4'd13
  } glyph_t;

  typedef struct packed {
    logic               dot;
    logic [GLYPH_W-1:0] glyph;
  } digit_t;

  function automatic logic [SEG_W-1:0] glyph_segments(input logic [GLYPH_W-1:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      GL_0:     seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      GL_1:     seg = SEG_B | SEG_C;
      GL_2:     seg = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
      GL_3:     seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
      GL_4:     seg = SEG_B | SEG_C | SEG_F | SEG_G;
      GL_5:     seg = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
      GL_6:     seg = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      GL_7:     seg = SEG_A | SEG_B | SEG_C;
      GL_8:     seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      GL_9:     seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
      GL_MINUS: seg = SEG_G;
      GL_P:     seg = SEG_A | SEG_B | SEG_F | SEG_G;
      GL_U:     seg = SEG_E | SEG_D | SEG_C;
      default:  seg = SEG_OFF;  // blank and unused codes
    endcase
    return seg;
  endfunction

endpackage

>>> design/sssd_in_if.sv
// ----------------------------------------------------------------------------
// sssd_in_if
// Input channel: tick or digit write beats.
// ----------------------------------------------------------------------------
interface sssd_in_if
  import sssd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [POS_W-1:0]   position;
  logic [GLYPH_W-1:0] glyph;
  logic               dot;

  modport source (output valid, cmd, position, glyph, dot, input ready);
  modport sink   (input valid, cmd, position, glyph, dot, output ready);
endinterface

>>> design/sssd_out_if.sv
// ----------------------------------------------------------------------------
// sssd_out_if
// Output channel: segment pattern and driven anode, one beat per input beat.
// ----------------------------------------------------------------------------
interface sssd_out_if
  import sssd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] segments;
  logic [POS_W-1:0] anode;

  modport source (output valid, segments, anode, input ready);
  modport sink   (input valid, segments, anode, output ready);
endinterface

>>> design/seven_segment_scan_dimmer_top.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_dimmer_top
// Scan driver for a multiplexed seven-segment display with dimmed positions.
// Every input beat (a tick or a digit write) yields one output beat with the
// segment pattern and anode as they stand after that beat. A beat is taken
// every cycle unless the output stalls; its result passes the input register
// to the segment/anode registers, which double as the output register. Ticks
// count a slot and a blanking counter; each slot lights the next position of
// a five-slot scan (positions 1 to 4, then one of the rest in rotation), and
// positions 1 to 4 start their blanking count at four times dim_level.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
module seven_segment_scan_dimmer_top
  import sssd_pkg::*;
#(
  parameter int NUM_POSITIONS = 12,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  sssd_in_if.sink                in_ch,
  sssd_out_if.source             out_ch
);

  localparam int IDX_W = $clog2(NUM_POSITIONS);
  localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;
  localparam logic [ROT_W-1:0] ROT_LAST = ROT_W'(NUM_POSITIONS - 5);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_POSITIONS);

  // configuration
  logic [PERIOD_W-1:0] slot_period;
  logic [PERIOD_W-1:0] blank_period;
  logic [DIM_W-1:0]    dim_level;

  // input register
  logic               s1_valid;
  logic               s1_cmd;
  logic [POS_W-1:0]   s1_position;
  logic [GLYPH_W-1:0] s1_glyph;
  logic               s1_dot;

  // scan state
  digit_t                 digit_store [NUM_POSITIONS];
  logic [SLOT_W-1:0]      main_slot, main_slot_next;
  logic [ROT_W-1:0]       rotate_offset, rotate_offset_next;
  logic [POS_W-1:0]       next_position, next_position_next;
  logic [COUNT_WIDTH-1:0] slot_count, slot_count_next;
  logic [COUNT_WIDTH-1:0] blank_count, blank_count_next;
  logic [SEG_W-1:0]       segment_reg, segment_reg_next;
  logic [POS_W-1:0]       anode_reg, anode_reg_next;
  logic                   out_valid;

  logic                   advance;
  logic                   do_tick;
  logic                   do_write;
  logic [COUNT_WIDTH-1:0] blank_inc;
  logic [COUNT_WIDTH-1:0] slot_inc;
  logic [PERIOD_W-1:0]    preset;
  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       wr_idx;
  digit_t                 rd_digit;
  logic                   pos_ok;
  logic                   wr_ok;

  assign advance      = s1_valid && (!out_valid || out_ch.ready);
  // hold off the input while in reset
  assign in_ch.ready  = !rst && (!s1_valid || advance);
  assign do_tick      = advance && (s1_cmd == CMD_TICK);
  assign do_write     = advance && (s1_cmd == CMD_WRITE);

  assign out_ch.valid    = out_valid;
  assign out_ch.segments = segment_reg;
  assign out_ch.anode    = anode_reg;

  assign rd_idx   = IDX_W'(next_position - POS_FIRST);
  assign wr_idx   = IDX_W'(s1_position - POS_FIRST);
  assign rd_digit = digit_store[rd_idx];
  assign pos_ok   = (next_position >= POS_FIRST) && (next_position <= POS_LAST);
  assign wr_ok    = (s1_position >= POS_FIRST) && (s1_position <= POS_LAST);
  assign blank_inc = blank_count + 1'b1;
  assign slot_inc  = slot_count + 1'b1;
  assign preset    = (next_position < POS_ROT_BASE) ? {dim_level, 2'b00} : '0;

  always_comb begin
    blank_count_next   = blank_count;
    slot_count_next    = slot_count;
    segment_reg_next   = segment_reg;
    anode_reg_next     = anode_reg;
    main_slot_next     = main_slot;
    rotate_offset_next = rotate_offset;
    next_position_next = next_position;
    if (do_tick) begin
      // blanking first, a slot event on the same tick overrides it
      if (CMP_W'(blank_inc) >= CMP_W'(blank_period)) begin
        blank_count_next = '0;
        segment_reg_next = SEG_OFF;
        anode_reg_next   = POS_NONE;
      end else begin
        blank_count_next = blank_inc;
      end
      if (CMP_W'(slot_inc) >= CMP_W'(slot_period)) begin
        slot_count_next = '0;
        if (pos_ok) begin
          segment_reg_next = glyph_segments(rd_digit.glyph) | (rd_digit.dot ? SEG_DP : SEG_OFF);
          anode_reg_next   = next_position;
        end else begin
          segment_reg_next = SEG_OFF;
          anode_reg_next   = POS_NONE;
        end
        if (preset >= blank_period) begin
          // preset at or past the blank point: drop the digit at once
          segment_reg_next = SEG_OFF;
          anode_reg_next   = POS_NONE;
          blank_count_next = '0;
        end else begin
          blank_count_next = COUNT_WIDTH'(preset);
        end
        if (main_slot == SLOT_ROTATED) begin
          next_position_next = POS_ROT_BASE + POS_W'(rotate_offset);
          rotate_offset_next = (rotate_offset == ROT_LAST) ? '0 : rotate_offset + 1'b1;
          main_slot_next     = SLOT_FIRST;
        end else begin
          next_position_next = POS_W'(main_slot);
          main_slot_next     = main_slot + 1'b1;
        end
      end else begin
        slot_count_next = slot_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_period  <= SLOT_PERIOD_RST;
      blank_period <= BLANK_PERIOD_RST;
      dim_level    <= DIM_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLOT_PERIOD:  slot_period  <= cfg_data;
        REG_BLANK_PERIOD: blank_period <= cfg_data;
        REG_DIM_LEVEL:    dim_level    <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_cmd      <= in_ch.cmd;
      s1_position <= in_ch.position;
      s1_glyph    <= in_ch.glyph;
      s1_dot      <= in_ch.dot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      main_slot     <= SLOT_FIRST;
      rotate_offset <= '0;
      next_position <= POS_FIRST;
      slot_count    <= '0;
      blank_count   <= '0;
      segment_reg   <= SEG_OFF;
      anode_reg     <= POS_NONE;
      for (int i = 0; i < NUM_POSITIONS; i++) begin
        digit_store[i] <= '0;
      end
    end else begin
      if (in_ch.ready) begin
        s1_valid <= in_ch.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      main_slot     <= main_slot_next;
      rotate_offset <= rotate_offset_next;
      next_position <= next_position_next;
      slot_count    <= slot_count_next;
      blank_count   <= blank_count_next;
      segment_reg   <= segment_reg_next;
      anode_reg     <= anode_reg_next;
      if (do_write && wr_ok) begin
        digit_store[wr_idx] <= '{dot: s1_dot, glyph: s1_glyph};
      end
    end
  end

`ifndef SYNTH
  a_dark_when_no_anode: assert property (@(posedge clk) disable iff (rst)
    (anode_reg == POS_NONE) |-> (segment_reg == SEG_OFF))
    else $error("segments lit with no anode driven");

  a_anode_range: assert property (@(posedge clk) disable iff (rst)
    anode_reg <= POS_LAST)
    else $error("anode beyond last position");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (next_position >= POS_FIRST) && (next_position <= POS_LAST) &&
    (main_slot >= SLOT_FIRST) && (main_slot <= SLOT_ROTATED))
    else $error("scan state out of range");

  a_write_holds_output: assert property (@(posedge clk) disable iff (rst)
    do_write |=> ($stable(segment_reg) && $stable(anode_reg) && $stable(slot_count)))
    else $error("digit write disturbed the scan");

  a_result_follows_beat: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("accepted beat produced no result");
`endif

endmodule

>>> sim/seven_segment_scan_dimmer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seven_segment_scan_dimmer_top_tb
// Self-checking bench for the seven-segment scan dimmer. A directed script
// covers the start after reset, unused glyph codes, writes to positions out
// of range, a dimming preset that blanks at once and zero periods. Random
// phases with fresh register settings follow. Each output beat is compared
// with a scan predictor kept in step with every accepted input beat, or with
// the view a script row types in. Both handshakes idle at random, and the
// output side holds off once for a long stretch so the block stalls its input.
// ----------------------------------------------------------------------------
module seven_segment_scan_dimmer_top_tb;
  import sssd_pkg::*;

  localparam int NPOS         = 12;
  localparam int LIMIT        = 200_000;
  localparam int PHASES       = 10;
  localparam int PHASE_BEATS  = 50;
  localparam int HOLD_AFTER   = 120;
  localparam int HOLD_CYCLES  = 400;

  localparam logic [GLYPH_W-1:0] GL_SPARE_E = 4'd14;
  localparam logic [GLYPH_W-1:0] GL_SPARE_F = 4'd15;

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic [POS_W-1:0] anode;
  } view_t;

  typedef struct packed {
    logic                new_cfg;
    logic [PERIOD_W-1:0] slot_p;
    logic [PERIOD_W-1:0] blank_p;
    logic [DIM_W-1:0]    dim_l;
    cmd_t                cmd;
    logic [POS_W-1:0]    pos;
    logic [GLYPH_W-1:0]  gly;
    logic                dot;
    logic                typed;
    logic [SEG_W-1:0]    seg;
    logic [POS_W-1:0]    an;
  } step_row_t;

  localparam int SCRIPT_LEN = 24;
  localparam step_row_t SCRIPT [SCRIPT_LEN] = '{
    // reset settings: nothing lit yet
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_TICK,  4'd0,  GL_0,       1'b0, 1'b1, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_WRITE, 4'd1,  GL_8,       1'b1, 1'b1, SEG_OFF, POS_NONE},
    // slot on every tick: position one is lit twice after reset
    '{1'b1, 16'd1, 16'd65535, 14'd0, CMD_TICK, 4'd0, GL_0,     1'b0, 1'b1, 8'hFF,   4'd1},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_TICK,  4'd0,  GL_0,       1'b0, 1'b1, 8'hFF,   4'd1},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_WRITE, 4'd2,  GL_MINUS,   1'b0, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_WRITE, 4'd3,  GL_SPARE_E, 1'b0, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_WRITE, 4'd4,  GL_SPARE_F, 1'b1, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_WRITE, 4'd5,  GL_P,       1'b0, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_WRITE, 4'd1,  GL_U,       1'b0, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_WRITE, 4'd0,  GL_8,       1'b1, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_WRITE, 4'd13, GL_8,       1'b1, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_WRITE, 4'd15, GL_8,       1'b1, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_WRITE, 4'd2,  GL_BLANK,   1'b1, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_TICK,  4'd0,  GL_0,       1'b0, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_TICK,  4'd0,  GL_0,       1'b0, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_TICK,  4'd0,  GL_0,       1'b0, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_TICK,  4'd0,  GL_0,       1'b0, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_TICK,  4'd0,  GL_0,       1'b0, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_TICK,  4'd0,  GL_0,       1'b0, 1'b0, SEG_OFF, POS_NONE},
    // dimming preset equal to the blank period: dimmed positions go dark
    '{1'b1, 16'd1, 16'd8, 14'd2, CMD_TICK,  4'd0,  GL_0,       1'b0, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_TICK,  4'd0,  GL_0,       1'b0, 1'b0, SEG_OFF, POS_NONE},
    // zero periods: both compares hold on every tick
    '{1'b1, 16'd0, 16'd0, 14'd16383, CMD_TICK, 4'd0, GL_0,     1'b0, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_TICK,  4'd0,  GL_0,       1'b0, 1'b0, SEG_OFF, POS_NONE},
    '{1'b0, 16'd0, 16'd0, 14'd0, CMD_TICK,  4'd0,  GL_0,       1'b0, 1'b0, SEG_OFF, POS_NONE}
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  sssd_in_if  in_ch ();
  sssd_out_if out_ch ();

  seven_segment_scan_dimmer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Scan predictor state
  digit_t              lit_digits [1:NPOS];
  logic [PERIOD_W-1:0] slot_period_q;
  logic [PERIOD_W-1:0] blank_period_q;
  logic [DIM_W-1:0]    dim_level_q;
  logic [SLOT_W-1:0]   scan_slot;
  logic [ROT_W-1:0]    rot_index;
  logic [POS_W-1:0]    pending_pos;
  logic [PERIOD_W-1:0] tick_count;
  logic [PERIOD_W-1:0] dark_count;
  view_t               shown;

  view_t pending_view [$];
  int    mismatch_count = 0;
  int    shown_count    = 0;
  int    cycle_count    = 0;
  bit    long_hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SEG_W-1:0] glyph_pattern(logic [GLYPH_W-1:0] g);
    logic [SEG_W-1:0] p;
    case (g)
      GL_0:     p = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      GL_1:     p = SEG_B | SEG_C;
      GL_2:     p = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
      GL_3:     p = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
      GL_4:     p = SEG_B | SEG_C | SEG_F | SEG_G;
      GL_5:     p = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
      GL_6:     p = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      GL_7:     p = SEG_A | SEG_B | SEG_C;
      GL_8:     p = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      GL_9:     p = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
      GL_MINUS: p = SEG_G;
      GL_P:     p = SEG_A | SEG_B | SEG_F | SEG_G;
      GL_U:     p = SEG_C | SEG_D | SEG_E;
      default:  p = SEG_OFF;
    endcase
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)      return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else             return $urandom_range(20, 60);
  endfunction

  task automatic clear_scan();
    for (int i = 1; i <= NPOS; i++) lit_digits[i] = '0;
    slot_period_q  = SLOT_PERIOD_RST;
    blank_period_q = BLANK_PERIOD_RST;
    dim_level_q    = DIM_LEVEL_RST;
    scan_slot      = SLOT_FIRST;
    rot_index      = '0;
    pending_pos    = POS_FIRST;
    tick_count     = '0;
    dark_count     = '0;
    shown          = '0;
  endtask

  task automatic light_position();
    int preset;
    preset = (pending_pos < POS_ROT_BASE) ? 4 * int'(dim_level_q) : 0;
    shown.segments = glyph_pattern(lit_digits[pending_pos].glyph) |
                     (lit_digits[pending_pos].dot ? SEG_DP : SEG_OFF);
    shown.anode    = pending_pos;
    if (preset >= int'(blank_period_q)) begin
      shown      = '0;
      dark_count = '0;
    end else begin
      dark_count = preset[PERIOD_W-1:0];
    end
    // advance the scan: slot five takes the next rotated position
    if (scan_slot == SLOT_ROTATED) begin
      pending_pos = POS_ROT_BASE + POS_W'(rot_index);
      rot_index   = (int'(rot_index) == NPOS - 5) ? '0 : rot_index + 1'b1;
    end else begin
      pending_pos = POS_W'(scan_slot);
    end
    scan_slot = (scan_slot == SLOT_ROTATED) ? SLOT_FIRST : scan_slot + 1'b1;
  endtask

  task automatic scan_predict(cmd_t c, logic [POS_W-1:0] p, logic [GLYPH_W-1:0] g,
                              logic d, output view_t v);
    if (c == CMD_WRITE) begin
      if (p >= 1 && p <= NPOS) lit_digits[p] = '{dot: d, glyph: g};
    end else begin
      dark_count = dark_count + 1'b1;
      if (dark_count >= blank_period_q) begin
        dark_count = '0;
        shown      = '0;
      end
      tick_count = tick_count + 1'b1;
      if (tick_count >= slot_period_q) begin
        tick_count = '0;
        light_position();
      end
    end
    v = shown;
  endtask

  task automatic send_beat(cmd_t c, logic [POS_W-1:0] p, logic [GLYPH_W-1:0] g, logic d,
                           logic typed, view_t typed_view);
    view_t v;
    int    gap;
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= c;
    in_ch.position <= p;
    in_ch.glyph    <= g;
    in_ch.dot      <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    scan_predict(c, p, g, d, v);
    pending_view.push_back(typed ? typed_view : v);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every beat has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_view.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(logic [PERIOD_W-1:0] sp, logic [PERIOD_W-1:0] bp,
                            logic [DIM_W-1:0] dl);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SLOT_PERIOD;
    cfg_data  <= sp;
    @(posedge clk);
    cfg_index <= REG_BLANK_PERIOD;
    cfg_data  <= bp;
    @(posedge clk);
    cfg_index <= REG_DIM_LEVEL;
    cfg_data  <= CFG_DATA_W'(dl);
    @(posedge clk);
    cfg_we <= 1'b0;
    slot_period_q  = sp;
    blank_period_q = bp;
    dim_level_q    = dl;
  endtask

  task automatic random_beat();
    cmd_t             c;
    logic [POS_W-1:0] p;
    c = ($urandom_range(0, 9) < 7) ? CMD_TICK : CMD_WRITE;
    p = ($urandom_range(0, 9) == 0) ? POS_W'($urandom_range(0, 15))
                                    : POS_W'($urandom_range(1, NPOS));
    send_beat(c, p, GLYPH_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  // Stimulus
  initial begin
    logic [PERIOD_W-1:0] sp, bp;
    logic [DIM_W-1:0]    dl;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_SLOT_PERIOD;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_TICK;
    in_ch.position <= '0;
    in_ch.glyph    <= '0;
    in_ch.dot      <= 1'b0;
    clear_scan();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].new_cfg) begin
        settle();
        set_config(SCRIPT[i].slot_p, SCRIPT[i].blank_p, SCRIPT[i].dim_l);
      end
      send_beat(SCRIPT[i].cmd, SCRIPT[i].pos, SCRIPT[i].gly, SCRIPT[i].dot,
                SCRIPT[i].typed, '{segments: SCRIPT[i].seg, anode: SCRIPT[i].an});
    end

    for (int k = 0; k < PHASES; k++) begin
      settle();
      case (k)
        0: begin sp = 16'd1;     bp = 16'd65535; dl = 14'd16383; end
        1: begin sp = 16'd65535; bp = 16'd1;     dl = 14'd0;     end
        2: begin sp = 16'd2;     bp = 16'd65535; dl = 14'd0;     end
        default: begin
          sp = ($urandom_range(0, 5) == 0) ? PERIOD_W'($urandom_range(6, 40))
                                           : PERIOD_W'($urandom_range(1, 5));
          bp = ($urandom_range(0, 7) == 0) ? 16'd65535 : PERIOD_W'($urandom_range(1, 30));
          dl = DIM_W'($urandom_range(0, 8));
        end
      endcase
      set_config(sp, bp, dl);
      repeat (PHASE_BEATS) random_beat();
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Output side: random stalls, one long hold-off to back up the input
  initial begin
    int gap;
    int burst;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && shown_count >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      burst = $urandom_range(1, 12);
      repeat (burst) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    view_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      shown_count++;
      if (pending_view.size() == 0) begin
        $error("result beat with nothing expected: segments %02h anode %0d",
               out_ch.segments, out_ch.anode);
        mismatch_count++;
      end else begin
        want = pending_view.pop_front();
        if (out_ch.segments !== want.segments) begin
          $error("segments: expected %02h, got %02h", want.segments, out_ch.segments);
          mismatch_count++;
        end
        if (out_ch.anode !== want.anode) begin
          $error("anode: expected %0d, got %0d", want.anode, out_ch.anode);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
